>>> hdl/rgbblt_pkg.sv
package rgbblt_pkg;

	localparam int DefMaxWidth  = 512;
	localparam int DefMaxHeight = 256;

	typedef enum logic [2:0] {
		ACT_CLEAR   = 3'd0,
		ACT_OUTLINE = 3'd1,
		ACT_FILL    = 3'd2,
		ACT_MONO    = 3'd3,
		ACT_COLOR   = 3'd4,
		ACT_DATA    = 3'd5,
		ACT_READ    = 3'd6,
		ACT_BAD     = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REJECT  = 2'd1,
		ST_STRAY   = 2'd2,
		ST_PENDING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PK_NONE  = 2'd0,
		PK_MONO  = 2'd1,
		PK_COLOR = 2'd2
	} pend_t;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'd0,
		CFG_HEIGHT = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SWEEP,
		S_FILL,
		S_OUT_TOP,
		S_OUT_BOT,
		S_OUT_LEFT,
		S_OUT_RIGHT,
		S_MONO,
		S_READ,
		S_RDATA,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] size_w;
		logic [15:0] size_h;
		logic [15:0] fore_color;
		logic [15:0] back_color;
		logic        transparent;
		logic [15:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pixel_color;
	} out_item_t;

endpackage

>>> hdl/rgb565_rect_and_bitmap_blitter.sv
// channel  | direction | payload
// in       | input     | rgbblt_pkg::in_item_t, valid/ready
// out      | output    | rgbblt_pkg::out_item_t, valid/ready
// cfg      | input     | we/idx/data, no wait
// one transaction at a time; ready drops while a command runs
// clear sweeps the active screen, fill writes the clipped rectangle row by row,
// outline walks the top, bottom, left and right edges of the clipped rectangle,
// mono data up to 8 pixels, colour data 1, read via S_READ, S_RDATA; one store write port
// after reset a sweep of the whole store blackens it and no transaction
// is taken until it ends
// a result waits in the output register; the next item waits for it to go
module rgb565_rect_and_bitmap_blitter #(
	parameter int MAX_WIDTH  = rgbblt_pkg::DefMaxWidth,
	parameter int MAX_HEIGHT = rgbblt_pkg::DefMaxHeight
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rgbblt_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rgbblt_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_idx,
	input  logic [9:0]            cfg_data
);
	import rgbblt_pkg::*;

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(Depth);
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);

	state_t      st_q, st_nx;
	logic [9:0]  sw_q;
	logic [8:0]  sh_q;
	pend_t       pend_q;
	logic [15:0] ox_q, oy_q, bw_q, bh_q, crow_q, ccol_q, fore_q, back_q;
	logic        tr_q;
	logic [15:0] dw_q;
	logic [16:0] x0_q, y0_q, x1_q, y1_q, cx_q, cy_q;
	logic [2:0]  bit_q;
	logic [AW:0] sweep_q;
	logic [1:0]  stat_q;
	logic        ov_q;
	logic [15:0] pix_q;
	logic [AW-1:0] raddr_q;

	logic [XW-1:0] ew;
	logic [YW-1:0] eh;
	logic [16:0]   wx, wy;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata, rdata;
	logic [AW+1:0] prod;

	assign ew = (32'(sw_q) > MAX_WIDTH)  ? XW'(MAX_WIDTH)  : XW'(sw_q);
	assign eh = (32'(sh_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
			sh_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_WIDTH:  sw_q <= cfg_data;
				CFG_HEIGHT: sh_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign in_ready  = (st_q == S_IDLE) && !ov_q && sweep_q[AW];
	assign out_valid = ov_q;
	assign out_data  = '{status: stat_q, pixel_color: pix_q};

	// pixel write with clip; y*w kept narrow
	always_comb begin
		wx = 17'(ox_q) + 17'(ccol_q);
		wy = 17'(oy_q) + 17'(crow_q);
		we = 1'b0;
		wdata = fore_q;
		unique case (st_q)
			S_FILL, S_OUT_TOP, S_OUT_BOT, S_OUT_LEFT, S_OUT_RIGHT: begin
				wx = cx_q;
				wy = cy_q;
				we = 1'b1;
			end
			S_MONO: begin
				if (pend_q == PK_COLOR) begin
					we = 1'b1;
					wdata = dw_q;
				end else begin
					wx = 17'(ox_q) + 17'(ccol_q) + 17'(bit_q);
					we = dw_q[3'd7 - bit_q] || !tr_q;
					wdata = dw_q[3'd7 - bit_q] ? fore_q : back_q;
					if (17'(ccol_q) + 17'(bit_q) >= 17'(bw_q))
						we = 1'b0;
				end
			end
			default: ;
		endcase
		if (wx >= 17'(ew) || wy >= 17'(eh))
			we = 1'b0;
		prod = (AW+2)'(wy[YW-1:0] * ew) + (AW+2)'(wx[XW-1:0]);
		waddr = prod[AW-1:0];
		if (!sweep_q[AW]) begin
			we = 1'b1;
			waddr = sweep_q[AW-1:0];
			wdata = '0;
		end else if (st_q == S_SWEEP) begin
			we = 1'b1;
			waddr = sweep_q[AW-1:0];
			wdata = '0;
		end
	end

	rgbblt_store #(.AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr_q), .rdata(rdata)
	);

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			S_IDLE: ;
			S_SWEEP:
				if (32'(sweep_q[AW-1:0]) + 1 >= 32'(ew) * 32'(eh) ||
				    32'(sweep_q[AW-1:0]) + 1 >= Depth)
					st_nx = S_DONE;
			S_FILL:
				if (cx_q + 1 >= x1_q && cy_q + 1 >= y1_q) st_nx = S_DONE;
			S_OUT_TOP:   if (cx_q >= x1_q) st_nx = S_OUT_BOT;
			S_OUT_BOT:   if (cx_q >= x1_q) st_nx = S_OUT_LEFT;
			S_OUT_LEFT:  if (cy_q >= y1_q) st_nx = S_OUT_RIGHT;
			S_OUT_RIGHT: if (cy_q >= y1_q) st_nx = S_DONE;
			S_MONO:      if (bit_q == 3'd7) st_nx = S_DONE;
			S_READ:      st_nx = S_RDATA;
			S_RDATA:     st_nx = S_DONE;
			S_DONE:      st_nx = S_IDLE;
			default:     st_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pend_q <= PK_NONE;
			ov_q <= 1'b0;
			sweep_q <= '0;
			ox_q <= '0; oy_q <= '0; bw_q <= '0; bh_q <= '0;
			crow_q <= '0; ccol_q <= '0; fore_q <= '0; back_q <= '0;
			tr_q <= 1'b0;
			stat_q <= '0;
			pix_q <= '0;
		end else begin
			if (!sweep_q[AW])
				sweep_q <= sweep_q + 1'b1;
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			st_q <= st_nx;
			unique case (st_q)
				S_SWEEP: sweep_q[AW-1:0] <= sweep_q[AW-1:0] + 1'b1;
				S_FILL: begin
					if (cx_q + 1 >= x1_q) begin
						cx_q <= x0_q;
						cy_q <= cy_q + 1'b1;
					end else
						cx_q <= cx_q + 1'b1;
				end
				S_OUT_TOP: begin
					cx_q <= (cx_q >= x1_q) ? x0_q : cx_q + 1'b1;
					cy_q <= (cx_q >= x1_q) ? y1_q : y0_q;
				end
				S_OUT_BOT: begin
					cx_q <= (cx_q >= x1_q) ? x0_q : cx_q + 1'b1;
					if (cx_q >= x1_q) cy_q <= y0_q;
				end
				S_OUT_LEFT: begin
					cy_q <= (cy_q >= y1_q) ? y0_q : cy_q + 1'b1;
					cx_q <= (cy_q >= y1_q) ? x1_q : x0_q;
				end
				S_OUT_RIGHT: cy_q <= cy_q + 1'b1;
				S_MONO: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 3'd7 && pend_q == PK_MONO) begin
						if (17'(ccol_q) + 17'd8 >= 17'(bw_q)) begin
							ccol_q <= '0;
							if (17'(crow_q) + 1 >= 17'(bh_q)) begin
								crow_q <= '0;
								pend_q <= PK_NONE;
							end else
								crow_q <= crow_q + 1'b1;
						end else
							ccol_q <= ccol_q + 16'd8;
					end
				end
				S_RDATA: pix_q <= rdata;
				S_DONE: ov_q <= 1'b1;
				default: ;
			endcase
			if (st_q == S_IDLE && in_valid && in_ready) begin
				stat_q <= ST_OK;
				pix_q <= '0;
				st_q <= S_DONE;
				bit_q <= '0;
				dw_q <= in_data.data_word;
				x0_q <= 17'(in_data.pos_x);
				y0_q <= 17'(in_data.pos_y);
				cx_q <= 17'(in_data.pos_x);
				cy_q <= 17'(in_data.pos_y);
				// fill end exclusive, outline end inclusive
				x1_q <= (17'(in_data.pos_x) + 17'(in_data.size_w) > 17'(ew)) ?
				        17'(ew) : 17'(in_data.pos_x) + 17'(in_data.size_w);
				y1_q <= (17'(in_data.pos_y) + 17'(in_data.size_h) > 17'(eh)) ?
				        17'(eh) : 17'(in_data.pos_y) + 17'(in_data.size_h);
				raddr_q <= AW'((AW+2)'(in_data.pos_y[YW-1:0] * ew)
				              + (AW+2)'(in_data.pos_x[XW-1:0]));
				if (action_t'(in_data.action) == ACT_BAD)
					stat_q <= ST_REJECT;
				else if (action_t'(in_data.action) == ACT_DATA) begin
					if (pend_q == PK_NONE)
						stat_q <= ST_STRAY;
					else if (pend_q == PK_MONO)
						st_q <= S_MONO;
					else begin
						// colour pixel takes the last mono slot only
						st_q <= S_MONO;
						bit_q <= 3'd7;
					end
				end else if (pend_q != PK_NONE)
					stat_q <= ST_PENDING;
				else if (ew == '0 || eh == '0)
					stat_q <= ST_REJECT;
				else if (action_t'(in_data.action) == ACT_CLEAR) begin
					sweep_q[AW-1:0] <= '0;
					st_q <= S_SWEEP;
				end else if (17'(in_data.pos_x) >= 17'(ew) ||
				             17'(in_data.pos_y) >= 17'(eh))
					stat_q <= ST_REJECT;
				else if (action_t'(in_data.action) == ACT_READ)
					st_q <= S_READ;
				else if (action_t'(in_data.action) == ACT_FILL) begin
					fore_q <= in_data.fore_color;
					if (in_data.size_w != '0 && in_data.size_h != '0)
						st_q <= S_FILL;
				end else if (in_data.size_w == '0 || in_data.size_h == '0)
					stat_q <= ST_REJECT;
				else if (action_t'(in_data.action) == ACT_OUTLINE) begin
					st_q <= S_OUT_TOP;
					fore_q <= in_data.fore_color;
					x1_q <= (17'(in_data.pos_x) + 17'(in_data.size_w) > 17'(ew)) ?
					        17'(ew) - 1'b1 :
					        17'(in_data.pos_x) + 17'(in_data.size_w) - 1'b1;
					y1_q <= (17'(in_data.pos_y) + 17'(in_data.size_h) > 17'(eh)) ?
					        17'(eh) - 1'b1 :
					        17'(in_data.pos_y) + 17'(in_data.size_h) - 1'b1;
				end else begin
					pend_q <= (action_t'(in_data.action) == ACT_MONO) ? PK_MONO : PK_COLOR;
					ox_q <= in_data.pos_x;
					oy_q <= in_data.pos_y;
					bw_q <= in_data.size_w;
					bh_q <= in_data.size_h;
					crow_q <= '0;
					ccol_q <= '0;
					fore_q <= in_data.fore_color;
					back_q <= in_data.back_color;
					tr_q <= in_data.transparent;
				end
			end
			// colour data takes the last slot of the mono path, then steps by one
			if (st_q == S_MONO && bit_q == 3'd7 && pend_q == PK_COLOR) begin
				if (17'(ccol_q) + 17'd1 >= 17'(bw_q)) begin
					ccol_q <= '0;
					if (17'(crow_q) + 1 >= 17'(bh_q)) begin
						crow_q <= '0;
						pend_q <= PK_NONE;
					end else
						crow_q <= crow_q + 1'b1;
				end else
					ccol_q <= ccol_q + 1'b1;
			end
		end
	end
endmodule

>>> hdl/rgbblt_store.sv
module rgbblt_store #(
	parameter int AW = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> tb/sv/rgbblt_checker.sv
`timescale 1ns / 100ps

module rgbblt_checker
	import rgbblt_pkg::*;
(
	input  logic      clk,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [9:0] cfg_data,
	output int        fail_cnt,
	output int        pend_cnt
);

	localparam int unsigned FB_DEPTH = DefMaxWidth * DefMaxHeight;

	logic [15:0] fb [0:FB_DEPTH-1];
	out_item_t   reply_q [$];

	int unsigned scr_w, scr_h;
	pend_t       open_kind;
	int unsigned org_x, org_y, bm_w, bm_h, row_at, col_at;
	logic [15:0] bm_fore, bm_back;
	logic        bm_skip_bg;

	initial begin
		for (int i = 0; i < FB_DEPTH; i++)
			fb[i] = '0;
		scr_w = 0;
		scr_h = 0;
		open_kind = PK_NONE;
		org_x = 0;
		org_y = 0;
		bm_w = 0;
		bm_h = 0;
		row_at = 0;
		col_at = 0;
		bm_fore = '0;
		bm_back = '0;
		bm_skip_bg = 1'b0;
		fail_cnt = 0;
		pend_cnt = 0;
	end

	function automatic int unsigned act_w();
		return (scr_w > DefMaxWidth) ? DefMaxWidth : scr_w;
	endfunction

	function automatic int unsigned act_h();
		return (scr_h > DefMaxHeight) ? DefMaxHeight : scr_h;
	endfunction

	function automatic void plot(int unsigned x, int unsigned y, logic [15:0] c);
		if (x < act_w() && y < act_h())
			fb[y * act_w() + x] = c;
	endfunction

	function automatic void step_cursor(int unsigned n);
		col_at += n;
		if (col_at >= bm_w) begin
			col_at = 0;
			row_at++;
			if (row_at >= bm_h) begin
				row_at = 0;
				open_kind = PK_NONE;
			end
		end
	endfunction

	function automatic out_item_t blit_predict(in_item_t it);
		out_item_t   r;
		int unsigned w, h, x, y, xe, ye, col;
		w = act_w();
		h = act_h();
		x = it.pos_x;
		y = it.pos_y;
		r.status = ST_OK;
		r.pixel_color = '0;
		if (action_t'(it.action) == ACT_BAD) begin
			r.status = ST_REJECT;
		end else if (action_t'(it.action) == ACT_DATA) begin
			if (open_kind == PK_NONE) begin
				r.status = ST_STRAY;
			end else if (open_kind == PK_MONO) begin
				for (int i = 0; i < 8; i++) begin
					col = col_at + i;
					if (col >= bm_w)
						break;
					if (it.data_word[7-i])
						plot(org_x + col, org_y + row_at, bm_fore);
					else if (!bm_skip_bg)
						plot(org_x + col, org_y + row_at, bm_back);
				end
				step_cursor(8);
			end else begin
				plot(org_x + col_at, org_y + row_at, it.data_word);
				step_cursor(1);
			end
		end else if (open_kind != PK_NONE) begin
			r.status = ST_PENDING;
		end else if (w == 0 || h == 0) begin
			r.status = ST_REJECT;
		end else if (action_t'(it.action) == ACT_CLEAR) begin
			for (int i = 0; i < w * h; i++)
				fb[i] = '0;
		end else if (x >= w || y >= h) begin
			r.status = ST_REJECT;
		end else if (action_t'(it.action) == ACT_READ) begin
			r.pixel_color = fb[(y * w + x) % FB_DEPTH];
		end else if (action_t'(it.action) == ACT_FILL) begin
			xe = (x + it.size_w > w) ? w : x + it.size_w;
			ye = (y + it.size_h > h) ? h : y + it.size_h;
			for (int j = y; j < ye; j++)
				for (int i = x; i < xe; i++)
					plot(i, j, it.fore_color);
		end else if (it.size_w == 0 || it.size_h == 0) begin
			r.status = ST_REJECT;
		end else if (action_t'(it.action) == ACT_OUTLINE) begin
			xe = (x + it.size_w - 1 >= w) ? w - 1 : x + it.size_w - 1;
			ye = (y + it.size_h - 1 >= h) ? h - 1 : y + it.size_h - 1;
			for (int i = x; i <= xe; i++) begin
				plot(i, y, it.fore_color);
				plot(i, ye, it.fore_color);
			end
			for (int j = y; j <= ye; j++) begin
				plot(x, j, it.fore_color);
				plot(xe, j, it.fore_color);
			end
		end else begin
			open_kind = (action_t'(it.action) == ACT_MONO) ? PK_MONO : PK_COLOR;
			org_x = x;
			org_y = y;
			bm_w = it.size_w;
			bm_h = it.size_h;
			row_at = 0;
			col_at = 0;
			bm_fore = it.fore_color;
			bm_back = it.back_color;
			bm_skip_bg = it.transparent;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (cfg_we) begin
			if (cfg_idx == CFG_WIDTH)
				scr_w = cfg_data;
			else
				scr_h = cfg_data[8:0];
		end
		if (in_valid && in_ready)
			reply_q.push_back(blit_predict(in_data));
		if (out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				$error("unexpected transaction: status %0d pixel %h",
					out_data.status, out_data.pixel_color);
				fail_cnt++;
			end else begin
				want = reply_q.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					fail_cnt++;
				end
				if (out_data.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %h, got %h",
						want.pixel_color, out_data.pixel_color);
					fail_cnt++;
				end
			end
		end
		pend_cnt = reply_q.size();
	end

endmodule

>>> tb/sv/tb_rgb565_rect_and_bitmap_blitter.sv
`timescale 1ns / 100ps

module tb_rgb565_rect_and_bitmap_blitter;
	import rgbblt_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RAND_ITEMS  = 1050;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_idx = '0;
	logic [9:0] cfg_data = '0;

	int fail_cnt, pend_cnt;
	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_req = 0;
	int hold_left = 0;
	int cyc = 0;
	int sent = 0;
	int scr_w = 0;
	int scr_h = 0;

	always #2 clk = ~clk;

	rgb565_rect_and_bitmap_blitter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	rgbblt_checker chk (
		.clk(clk), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_cnt(fail_cnt), .pend_cnt(pend_cnt)
	);

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_req = 0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb_rgb565_rect_and_bitmap_blitter: errors");
			$finish;
		end
	end

	task automatic send(in_item_t it);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_screen(int w, int h);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= CFG_WIDTH;
		cfg_data <= w[9:0];
		@(posedge clk);
		cfg_idx <= CFG_HEIGHT;
		cfg_data <= h[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w = (w > DefMaxWidth) ? DefMaxWidth : w;
		scr_h = (h > DefMaxHeight) ? DefMaxHeight : h;
	endtask

	function automatic in_item_t mk(action_t a, int x, int y, int w, int h);
		in_item_t it;
		it.action = a;
		it.pos_x = x[15:0];
		it.pos_y = y[15:0];
		it.size_w = w[15:0];
		it.size_h = h[15:0];
		it.fore_color = 16'($urandom);
		it.back_color = 16'($urandom);
		it.transparent = 1'($urandom_range(1));
		it.data_word = 16'($urandom);
		return it;
	endfunction

	task automatic send_data(int n, bit extremes);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it = mk(ACT_DATA, $urandom, $urandom, $urandom, $urandom);
			if (extremes)
				it.data_word = i[0] ? 16'h0000 : 16'hFFFF;
			send(it);
		end
	endtask

	task automatic send_bitmap(action_t a, int x, int y, int w, int h, bit tr, bit spoil);
		in_item_t it;
		int n;
		n = (a == ACT_MONO) ? ((w + 7) / 8) * h : w * h;
		it = mk(a, x, y, w, h);
		it.transparent = tr;
		send(it);
		if (spoil && n > 1) begin
			// a command while data is still owed
			send_data(n / 2, 1'b0);
			send(mk(action_t'($urandom_range(4)), $urandom, $urandom, 3, 3));
			send(mk(ACT_READ, 0, 0, 0, 0));
			send_data(n - n / 2, 1'b0);
		end else
			send_data(n, 1'b0);
	endtask

	function automatic int coord(int lim);
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(65535);
		if (pick < 20)
			return lim - 1 + $urandom_range(2);
		return $urandom_range(lim > 0 ? lim - 1 : 0);
	endfunction

	task automatic random_op();
		int pick, x, y, w, h;
		action_t a;
		pick = $urandom_range(99);
		x = coord(scr_w);
		y = coord(scr_h);
		if (pick < 35) begin
			a = ($urandom_range(1) != 0) ? ACT_MONO : ACT_COLOR;
			w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
			h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
			if (x >= scr_w || y >= scr_h || w == 0 || h == 0)
				send(mk(a, x, y, w, h));
			else
				send_bitmap(a, x, y, w, h, 1'($urandom_range(1)), $urandom_range(7) == 0);
			return;
		end
		if (pick < 40)
			a = ($urandom_range(3) == 0) ? ACT_CLEAR : ACT_BAD;
		else if (pick < 45)
			a = ACT_DATA;
		else if (pick < 60)
			a = ACT_OUTLINE;
		else if (pick < 75)
			a = ACT_FILL;
		else
			a = ACT_READ;
		if ($urandom_range(7) == 0) begin
			w = $urandom_range(65535);
			h = $urandom_range(65535);
		end else begin
			w = $urandom_range(scr_w + 3);
			h = $urandom_range(scr_h + 3);
		end
		send(mk(a, x, y, w, h));
	endtask

	initial begin
		int phase_len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unconfigured screen
		send(mk(ACT_READ, 0, 0, 1, 1));
		send(mk(ACT_CLEAR, 0, 0, 1, 1));
		send(mk(ACT_DATA, 0, 0, 1, 1));
		send(mk(ACT_BAD, 0, 0, 1, 1));

		// oversized registers clamp to the full store
		set_screen(1023, 511);
		send(mk(ACT_FILL, 500, 250, 65535, 65535));
		send(mk(ACT_READ, 511, 255, 0, 0));
		send(mk(ACT_READ, 512, 0, 0, 0));
		send(mk(ACT_READ, 65535, 65535, 0, 0));
		send(mk(ACT_OUTLINE, 0, 0, 65535, 65535));
		send(mk(ACT_OUTLINE, 3, 3, 0, 4));
		send(mk(ACT_FILL, 3, 3, 0, 0));
		send(mk(ACT_MONO, 3, 3, 5, 0));
		send(mk(ACT_COLOR, 512, 3, 5, 5));
		send_bitmap(ACT_MONO, 508, 254, 10, 3, 1'b0, 1'b1);
		send_bitmap(ACT_MONO, 505, 100, 12, 2, 1'b1, 1'b0);
		send(mk(ACT_COLOR, 510, 255, 3, 2));
		send_data(6, 1'b1);
		send(mk(ACT_READ, 511, 255, 0, 0));
		send(mk(ACT_CLEAR, 0, 0, 0, 0));
		send(mk(ACT_READ, 0, 0, 0, 0));

		set_screen(0, 256);
		send(mk(ACT_FILL, 0, 0, 4, 4));
		set_screen(512, 0);
		send(mk(ACT_READ, 0, 0, 0, 0));

		phase_len = RAND_ITEMS / 3;
		set_screen(1, 1);
		snd_idle = 7;
		rcv_idle = 46;
		// receiver holds off while the sender keeps offering
		hold_req = 1;
		while (sent < 30 + RAND_ITEMS) begin
			if (sent > 30 + phase_len && snd_idle == 7) begin
				snd_idle = 46;
				rcv_idle = 7;
			end else if (sent > 30 + 2 * phase_len && snd_idle == 46) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if ($urandom_range(59) == 0)
				set_screen($urandom_range(1, 40), $urandom_range(1, 24));
			else if ($urandom_range(199) == 0)
				set_screen($urandom_range(1) ? 0 : 8, $urandom_range(1) ? 0 : 8);
			if ($urandom_range(99) == 0)
				hold_req = 1;
			if ($urandom_range(149) == 0)
				drain();
			random_op();
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_rgb565_rect_and_bitmap_blitter: clean");
		else
			$display("tb_rgb565_rect_and_bitmap_blitter: errors");
		$finish;
	end

endmodule

>>> filelist.f
hdl/rgbblt_pkg.sv
hdl/rgbblt_store.sv
hdl/rgb565_rect_and_bitmap_blitter.sv
tb/sv/rgbblt_checker.sv
tb/sv/tb_rgb565_rect_and_bitmap_blitter.sv
